FILE: rtl/core/tsae_pkg.sv
// shared types, constants and decode for the thumb shift and adc execute block
`default_nettype none

package tsae_pkg;

  localparam int DATA_W     = 32;
  localparam int REG_COUNT  = 8;
  localparam int REG_ADDR_W = 3;
  localparam int INSN_W     = 16;
  localparam int SHIFT_W    = 8;

  localparam logic [SHIFT_W-1:0] SHIFT_FULL = 8'd32;

  // opcode fields of the five legal encodings
  localparam logic [4:0] TOP5_LSL_IMM  = 5'b00000;
  localparam logic [4:0] TOP5_LSR_IMM  = 5'b00001;
  localparam logic [9:0] TOP10_LSL_REG = 10'h102;
  localparam logic [9:0] TOP10_LSR_REG = 10'h103;
  localparam logic [9:0] TOP10_ADC_REG = 10'h105;

  typedef enum logic [2:0] {
    OP_LSL_IMM,
    OP_LSR_IMM,
    OP_LSL_REG,
    OP_LSR_REG,
    OP_ADC,
    OP_WRITE,
    OP_ILLEGAL
  } op_t;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  typedef struct packed {
    logic [DATA_W-1:0]     result;
    flags_t                flags;
    logic                  illegal;
    logic                  wr_en;
    logic [REG_ADDR_W-1:0] wr_addr;
  } alu_out_t;

  function automatic op_t decode(logic command, logic [INSN_W-1:0] insn);
    op_t op;
    if (command) begin
      op = OP_WRITE;
    end else if (insn[15:11] == TOP5_LSL_IMM) begin
      op = OP_LSL_IMM;
    end else if (insn[15:11] == TOP5_LSR_IMM) begin
      op = OP_LSR_IMM;
    end else if (insn[15:6] == TOP10_LSL_REG) begin
      op = OP_LSL_REG;
    end else if (insn[15:6] == TOP10_LSR_REG) begin
      op = OP_LSR_REG;
    end else if (insn[15:6] == TOP10_ADC_REG) begin
      op = OP_ADC;
    end else begin
      op = OP_ILLEGAL;
    end
    return op;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/thumb_shift_adc_execute.sv
// top level of the thumb shift and adc execute unit
//
// usage
//   input channel (in_valid / in_ready) carries one beat per step: command,
//   instruction, reg_index and reg_value. command 1 writes reg_value into
//   register reg_index, command 0 executes instruction (lsl / lsr immediate,
//   lsl / lsr register, adc register) on the eight-entry register file
//   output channel (out_valid / out_ready) returns exactly one beat per input
//   beat: result, flag_n, flag_z, flag_c, flag_v and illegal
//   stages: one input register (operand read from the register ram) and
//   one result register, which loads as a beat leaves the operand stage
//   throughput: one beat per cycle unless the receiver stalls; register
//   file and flags are written as a beat leaves the operand stage, and a
//   read that hits that write is forwarded, so dependent instructions
//   follow back to back
//   reset: both stages empty, flags and all registers read as zero at once
//   (per-register written bits, no clearing pass)
//   receiver stall: the result register holds; the operand stage holds one
//   more beat, then in_ready drops until the output drains
`default_nettype none

module thumb_shift_adc_execute (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            command,
  input  wire logic [tsae_pkg::INSN_W-1:0]     instruction,
  input  wire logic [tsae_pkg::REG_ADDR_W-1:0] reg_index,
  input  wire logic [tsae_pkg::DATA_W-1:0]     reg_value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [tsae_pkg::DATA_W-1:0]     result,
  output logic                                 flag_n,
  output logic                                 flag_z,
  output logic                                 flag_c,
  output logic                                 flag_v,
  output logic                                 illegal
);

  // operand stage
  logic                            s1_valid;
  logic                            s1_command;
  logic [tsae_pkg::INSN_W-1:0]     s1_insn;
  logic [tsae_pkg::REG_ADDR_W-1:0] s1_reg_index;
  logic [tsae_pkg::DATA_W-1:0]     s1_reg_value;
  logic                            fwd_mid;
  logic                            fwd_lo;
  logic [tsae_pkg::DATA_W-1:0]     fwd_data;
  logic                            known_mid;
  logic                            known_lo;

  // architectural state
  logic [tsae_pkg::REG_COUNT-1:0]  reg_written;
  tsae_pkg::flags_t                flags;

  logic                            in_beat;
  logic                            s1_advance;
  logic [tsae_pkg::DATA_W-1:0]     ram_q_mid;
  logic [tsae_pkg::DATA_W-1:0]     ram_q_lo;
  logic [tsae_pkg::DATA_W-1:0]     rm_val;
  logic [tsae_pkg::DATA_W-1:0]     rdn_val;
  logic                            wr_en;
  tsae_pkg::alu_out_t              alu_out;

  // operand stage moves on whenever the result register is free or draining
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign in_beat    = in_valid && in_ready;
  assign wr_en      = s1_advance && alu_out.wr_en;

  // both operand fields are read for every beat, whatever the encoding
  tsae_ram #(
    .WIDTH (tsae_pkg::DATA_W),
    .DEPTH (tsae_pkg::REG_COUNT)
  ) u_regs (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (alu_out.wr_addr),
    .wdata  (alu_out.result),
    .re     (in_beat),
    .raddr0 (instruction[5:3]),
    .raddr1 (instruction[2:0]),
    .rdata0 (ram_q_mid),
    .rdata1 (ram_q_lo)
  );

  // forwarded write wins, then unwritten registers read as zero
  assign rm_val  = fwd_mid ? fwd_data : (known_mid ? ram_q_mid : '0);
  assign rdn_val = fwd_lo  ? fwd_data : (known_lo  ? ram_q_lo  : '0);

  tsae_alu u_alu (
    .command     (s1_command),
    .instruction (s1_insn),
    .reg_index   (s1_reg_index),
    .reg_value   (s1_reg_value),
    .rm_val      (rm_val),
    .rdn_val     (rdn_val),
    .flags_in    (flags),
    .alu_out     (alu_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      reg_written <= '0;
      flags       <= '0;
    end else begin
      if (in_beat) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end

      if (s1_advance) begin
        out_valid <= 1'b1;
        flags     <= alu_out.flags;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (wr_en) begin
        reg_written[alu_out.wr_addr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_command   <= command;
      s1_insn      <= instruction;
      s1_reg_index <= reg_index;
      s1_reg_value <= reg_value;
      fwd_mid      <= wr_en && (alu_out.wr_addr == instruction[5:3]);
      fwd_lo       <= wr_en && (alu_out.wr_addr == instruction[2:0]);
      fwd_data     <= alu_out.result;
      known_mid    <= reg_written[instruction[5:3]];
      known_lo     <= reg_written[instruction[2:0]];
    end
    if (s1_advance) begin
      result  <= alu_out.result;
      flag_n  <= alu_out.flags.n;
      flag_z  <= alu_out.flags.z;
      flag_c  <= alu_out.flags.c;
      flag_v  <= alu_out.flags.v;
      illegal <= alu_out.illegal;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tsae_ram.sv
// generic ram, one write port and two registered read ports
`default_nettype none

module tsae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tsae_alu.sv
// combinational execute logic: decode, barrel shift, adc and flag update
`default_nettype none

module tsae_alu (
  input  wire logic                              command,
  input  wire logic [tsae_pkg::INSN_W-1:0]       instruction,
  input  wire logic [tsae_pkg::REG_ADDR_W-1:0]   reg_index,
  input  wire logic [tsae_pkg::DATA_W-1:0]       reg_value,
  input  wire logic [tsae_pkg::DATA_W-1:0]       rm_val,
  input  wire logic [tsae_pkg::DATA_W-1:0]       rdn_val,
  input  wire tsae_pkg::flags_t                  flags_in,
  output tsae_pkg::alu_out_t                     alu_out
);

  tsae_pkg::op_t                   op;
  logic [4:0]                      imm5;
  logic [tsae_pkg::DATA_W-1:0]     shift_x;
  logic [tsae_pkg::SHIFT_W-1:0]    shift_n;
  logic [tsae_pkg::DATA_W:0]       left_w;
  logic [tsae_pkg::DATA_W:0]       right_w;
  logic                            shift_over;
  logic                            shift_none;
  logic [tsae_pkg::DATA_W:0]       sum;
  logic [tsae_pkg::DATA_W-1:0]     res;
  logic                            carry;

  always_comb begin
    op   = tsae_pkg::decode(command, instruction);
    imm5 = instruction[10:6];

    // immediate forms shift Rm, register forms shift Rdn by Rm[7:0]
    if (op == tsae_pkg::OP_LSL_IMM || op == tsae_pkg::OP_LSR_IMM) begin
      shift_x = rm_val;
    end else begin
      shift_x = rdn_val;
    end

    case (op)
      tsae_pkg::OP_LSL_IMM: shift_n = {3'b000, imm5};
      tsae_pkg::OP_LSR_IMM: shift_n = (imm5 == 5'd0) ? tsae_pkg::SHIFT_FULL : {3'b000, imm5};
      default:              shift_n = rm_val[tsae_pkg::SHIFT_W-1:0];
    endcase

    // extra bit catches the last bit shifted out, valid up to a shift of 32
    left_w     = {1'b0, shift_x} << shift_n[5:0];
    right_w    = {shift_x, 1'b0} >> shift_n[5:0];
    shift_over = shift_n > tsae_pkg::SHIFT_FULL;
    shift_none = shift_n == '0;

    sum = {1'b0, rdn_val} + {1'b0, rm_val} + {{tsae_pkg::DATA_W{1'b0}}, flags_in.c};

    res   = '0;
    carry = flags_in.c;
    case (op)
      tsae_pkg::OP_LSL_IMM, tsae_pkg::OP_LSL_REG: begin
        if (shift_none) begin
          res = shift_x;
        end else if (!shift_over) begin
          res   = left_w[tsae_pkg::DATA_W-1:0];
          carry = left_w[tsae_pkg::DATA_W];
        end else begin
          carry = 1'b0;
        end
      end
      tsae_pkg::OP_LSR_IMM, tsae_pkg::OP_LSR_REG: begin
        if (shift_none) begin
          res = shift_x;
        end else if (!shift_over) begin
          res   = right_w[tsae_pkg::DATA_W:1];
          carry = right_w[0];
        end else begin
          carry = 1'b0;
        end
      end
      tsae_pkg::OP_ADC: begin
        res   = sum[tsae_pkg::DATA_W-1:0];
        carry = sum[tsae_pkg::DATA_W];
      end
      tsae_pkg::OP_WRITE: res = reg_value;
      default:            res = '0;
    endcase

    alu_out.result  = res;
    alu_out.flags   = flags_in;
    alu_out.illegal = 1'b0;
    alu_out.wr_en   = 1'b1;
    alu_out.wr_addr = instruction[2:0];
    case (op)
      tsae_pkg::OP_WRITE: begin
        alu_out.wr_addr = reg_index;
      end
      tsae_pkg::OP_ILLEGAL: begin
        alu_out.illegal = 1'b1;
        alu_out.wr_en   = 1'b0;
      end
      tsae_pkg::OP_ADC: begin
        alu_out.flags.n = res[tsae_pkg::DATA_W-1];
        alu_out.flags.z = (res == '0);
        alu_out.flags.c = carry;
        alu_out.flags.v = ((rdn_val[tsae_pkg::DATA_W-1] ^ res[tsae_pkg::DATA_W-1]) &
                           (rm_val[tsae_pkg::DATA_W-1] ^ res[tsae_pkg::DATA_W-1]));
      end
      default: begin
        // shifts keep v
        alu_out.flags.n = res[tsae_pkg::DATA_W-1];
        alu_out.flags.z = (res == '0);
        alu_out.flags.c = carry;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/tsae_checker.sv
// port-level checks for the execute unit, bound to the top level
`default_nettype none

module tsae_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [tsae_pkg::DATA_W-1:0]     result,
  input wire logic                            flag_n,
  input wire logic                            flag_z,
  input wire logic                            flag_c,
  input wire logic                            flag_v,
  input wire logic                            illegal
);

  logic [1:0]       pending;
  tsae_pkg::flags_t last_flags;
  logic             in_beat;
  logic             out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // beats in flight and the flags of the last delivered beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      last_flags <= '0;
    end else begin
      pending <= pending + {1'b0, in_beat} - {1'b0, out_beat};
      if (out_beat) begin
        last_flags <= '{n: flag_n, z: flag_z, c: flag_c, v: flag_v};
      end
    end
  end

  a_no_invented_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("output beat without a matching input beat");

  a_illegal_keeps_flags: assert property (@(posedge clk) disable iff (rst)
    out_beat && illegal |->
      (flag_n == last_flags.n) && (flag_z == last_flags.z) &&
      (flag_c == last_flags.c) && (flag_v == last_flags.v))
    else $error("illegal encoding changed the flags");

  a_illegal_zero_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && illegal |-> result == '0)
    else $error("illegal encoding returned a nonzero result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result) && $stable(illegal))
    else $error("stalled output beat changed");

endmodule

bind thumb_shift_adc_execute tsae_checker u_tsae_checker (.*);

`default_nettype wire

FILE: verif/thumb_shift_adc_execute_test.sv
// self-checking testbench for the thumb shift and adc execute unit
`default_nettype none

module thumb_shift_adc_execute_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tsae_pkg::*;

  // one expected result beat
  typedef struct {
    logic [DATA_W-1:0] result;
    flags_t            flags;
    logic              illegal;
  } exec_result_t;

  // shadow of the register file and flags; works out the result of every
  // accepted beat and checks the returned beats in order
  class exec_scoreboard;
    logic [DATA_W-1:0] regs [REG_COUNT];
    flags_t            fl;
    exec_result_t      awaited_q [$];
    int                op_seen [7];
    int                checked;
    int                failures;

    function new();
      foreach (regs[k]) regs[k] = '0;
      fl       = '0;
      checked  = 0;
      failures = 0;
      foreach (op_seen[k]) op_seen[k] = 0;
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction

    // zero keeps the carry, 32 takes bit 0, beyond that the carry clears
    function logic [DATA_W-1:0] lsl_by(logic [DATA_W-1:0] x, int unsigned n, inout logic c);
      if (n == 0) return x;
      if (n < 32) begin
        c = x[32-n];
        return x << n;
      end
      c = (n == 32) && x[0];
      return '0;
    endfunction

    function logic [DATA_W-1:0] lsr_by(logic [DATA_W-1:0] x, int unsigned n, inout logic c);
      if (n == 0) return x;
      if (n < 32) begin
        c = x[n-1];
        return x >> n;
      end
      c = (n == 32) && x[31];
      return '0;
    endfunction

    function void note_beat(logic cmd, logic [INSN_W-1:0] insn,
                            logic [REG_ADDR_W-1:0] idx, logic [DATA_W-1:0] val);
      op_t                   op;
      logic [REG_ADDR_W-1:0] lo;
      logic [REG_ADDR_W-1:0] mid;
      logic [4:0]            imm;
      logic [DATA_W-1:0]     a;
      logic [DATA_W-1:0]     b;
      logic [DATA_W-1:0]     r;
      logic [DATA_W:0]       sum;
      logic                  c;
      exec_result_t          e;
      lo  = insn[2:0];
      mid = insn[5:3];
      imm = insn[10:6];
      r   = '0;
      c   = fl.c;
      e.illegal = 1'b0;
      if (cmd) op = OP_WRITE;
      else if (insn[15:11] == TOP5_LSL_IMM) op = OP_LSL_IMM;
      else if (insn[15:11] == TOP5_LSR_IMM) op = OP_LSR_IMM;
      else if (insn[15:6] == TOP10_LSL_REG) op = OP_LSL_REG;
      else if (insn[15:6] == TOP10_LSR_REG) op = OP_LSR_REG;
      else if (insn[15:6] == TOP10_ADC_REG) op = OP_ADC;
      else op = OP_ILLEGAL;
      case (op)
        OP_WRITE: begin
          regs[idx] = val;
          r = val;
        end
        OP_LSL_IMM: r = lsl_by(regs[mid], int'(imm), c);
        OP_LSR_IMM: r = lsr_by(regs[mid], (imm == 5'd0) ? 32 : int'(imm), c);
        OP_LSL_REG: r = lsl_by(regs[lo], int'(regs[mid][7:0]), c);
        OP_LSR_REG: r = lsr_by(regs[lo], int'(regs[mid][7:0]), c);
        OP_ADC: begin
          a    = regs[lo];
          b    = regs[mid];
          sum  = {1'b0, a} + {1'b0, b} + (DATA_W+1)'(fl.c);
          r    = sum[DATA_W-1:0];
          c    = sum[DATA_W];
          fl.v = (a[31] ^ r[31]) & (b[31] ^ r[31]);
        end
        default: e.illegal = 1'b1;
      endcase
      if (op != OP_WRITE && op != OP_ILLEGAL) begin
        regs[lo] = r;
        fl.c = c;
        fl.n = r[31];
        fl.z = (r == '0);
      end
      e.result = r;
      e.flags  = fl;
      awaited_q.push_back(e);
      op_seen[op]++;
    endfunction

    function void check_beat(logic [DATA_W-1:0] res, flags_t f, logic ill);
      exec_result_t e;
      if (awaited_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result beat: result %h flags %b illegal %b", res, f, ill);
        return;
      end
      e = awaited_q.pop_front();
      checked++;
      if (res !== e.result || f !== e.flags || ill !== e.illegal) begin
        failures++;
        if (failures <= 10)
          $display("mismatch on result %0d: expected result %h nzcv %b illegal %b, got %h %b %b",
                   checked, e.result, e.flags, e.illegal, res, f, ill);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  command;
  logic [INSN_W-1:0]     instruction;
  logic [REG_ADDR_W-1:0] reg_index;
  logic [DATA_W-1:0]     reg_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [DATA_W-1:0]     result;
  logic                  flag_n;
  logic                  flag_z;
  logic                  flag_c;
  logic                  flag_v;
  logic                  illegal;

  exec_scoreboard sb = new();

  // sender idles not at all through a calm stretch
  int calm_items = 0;

  thumb_shift_adc_execute dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .instruction (instruction),
    .reg_index   (reg_index),
    .reg_value   (reg_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result      (result),
    .flag_n      (flag_n),
    .flag_z      (flag_z),
    .flag_c      (flag_c),
    .flag_v      (flag_v),
    .illegal     (illegal)
  );

  always #1 clk = ~clk;

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [INSN_W-1:0] imm_form(logic [4:0] top, logic [4:0] imm,
                                                 logic [2:0] rm, logic [2:0] rd);
    return {top, imm, rm, rd};
  endfunction

  function automatic logic [INSN_W-1:0] reg_form(logic [9:0] top, logic [2:0] rm,
                                                 logic [2:0] rdn);
    return {top, rm, rdn};
  endfunction

  // random instruction word: mostly the five legal forms with random fields,
  // the rest near-miss opcodes and fully random words
  function automatic logic [INSN_W-1:0] pick_insn();
    int         r;
    int         s;
    logic [4:0] imm;
    logic [2:0] rm;
    logic [2:0] rd;
    r   = $urandom_range(0, 99);
    s   = $urandom_range(0, 7);
    rm  = 3'($urandom_range(0, 7));
    rd  = 3'($urandom_range(0, 7));
    imm = (s == 0) ? 5'd0 : (s == 1) ? 5'd31 : 5'($urandom_range(0, 31));
    if (r < 15) return imm_form(TOP5_LSL_IMM, imm, rm, rd);
    if (r < 30) return imm_form(TOP5_LSR_IMM, imm, rm, rd);
    if (r < 48) return reg_form(TOP10_LSL_REG, rm, rd);
    if (r < 66) return reg_form(TOP10_LSR_REG, rm, rd);
    if (r < 88) return reg_form(TOP10_ADC_REG, rm, rd);
    if (r < 94) return {6'b010000, 4'($urandom_range(0, 15)), rm, rd};
    return 16'($urandom_range(0, 65535));
  endfunction

  // register values: small shift counts, corners, a chosen low byte, or anything
  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom_range(0, 40);
    if (r == 3) begin
      case ($urandom_range(0, 7))
        0: return 32'h0000_0000;
        1: return 32'h0000_0001;
        2: return 32'h7FFF_FFFF;
        3: return 32'h8000_0000;
        4: return 32'hFFFF_FFFF;
        5: return 32'h0000_0020;
        6: return 32'h0000_0100;
        default: return 32'h0000_00FF;
      endcase
    end
    if (r == 4) return {24'($urandom), 8'($urandom_range(0, 40))};
    return $urandom;
  endfunction

  // present one beat after a random gap and hold it until it is taken
  task automatic send_beat(logic cmd, logic [INSN_W-1:0] insn,
                           logic [REG_ADDR_W-1:0] idx, logic [DATA_W-1:0] val);
    int gap;
    if (calm_items > 0) begin
      calm_items--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 49) == 0) calm_items = $urandom_range(30, 100);
      gap = idle_len();
    end
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    command     <= cmd;
    instruction <= insn;
    reg_index   <= idx;
    reg_value   <= val;
    do @(posedge clk); while (!in_ready);
    sb.note_beat(cmd, insn, idx, val);
  endtask

  // write command; the instruction field is junk and must be ignored
  task automatic write_reg(logic [REG_ADDR_W-1:0] idx, logic [DATA_W-1:0] val);
    send_beat(1'b1, 16'($urandom), idx, val);
  endtask

  // execute; index and value fields are junk and must be ignored
  task automatic exec_insn(logic [INSN_W-1:0] insn);
    send_beat(1'b0, insn, 3'($urandom), $urandom);
  endtask

  // result side stalls: short runs with stalls of random length, and calm
  // stretches where ready stays high
  initial begin
    int run;
    int stall;
    out_ready <= 1'b0;
    forever begin
      if ($urandom_range(0, 7) == 0) begin
        run   = $urandom_range(50, 200);
        stall = 0;
      end else begin
        run   = $urandom_range(1, 8);
        stall = idle_len();
      end
      repeat (run) begin
        @(negedge clk);
        out_ready <= 1'b1;
      end
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
    end
  end

  // result beats are checked at the rising edge they are taken
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_beat(result, flags_t'({flag_n, flag_z, flag_c, flag_v}), illegal);
  end

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("thumb_shift_adc_execute_test NOT OK");
    $finish;
  end

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    command     <= 1'b0;
    instruction <= '0;
    reg_index   <= '0;
    reg_value   <= '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: corner operands first
    write_reg(3'd0, 32'hFFFF_FFFF);
    write_reg(3'd1, 32'h8000_0000);
    write_reg(3'd2, 32'h7FFF_FFFF);
    write_reg(3'd3, 32'd32);
    write_reg(3'd4, 32'd33);
    write_reg(3'd5, 32'h0000_0100);   // shift count byte of zero, upper bits set
    write_reg(3'd6, 32'd1);
    // lsl immediate of zero passes rm through with carry kept
    exec_insn(imm_form(TOP5_LSL_IMM, 5'd0, 3'd0, 3'd7));
    exec_insn(imm_form(TOP5_LSL_IMM, 5'd31, 3'd0, 3'd7));
    // lsr immediate of zero is a shift by 32
    exec_insn(imm_form(TOP5_LSR_IMM, 5'd0, 3'd1, 3'd7));
    exec_insn(imm_form(TOP5_LSR_IMM, 5'd31, 3'd1, 3'd7));
    // register shift by zero keeps the carry
    exec_insn(reg_form(TOP10_LSL_REG, 3'd5, 3'd0));
    // register shift by exactly 32, both directions
    exec_insn(reg_form(TOP10_LSL_REG, 3'd3, 3'd6));
    exec_insn(reg_form(TOP10_LSR_REG, 3'd3, 3'd1));
    // register shift beyond 32 clears result and carry
    exec_insn(reg_form(TOP10_LSR_REG, 3'd4, 3'd0));
    write_reg(3'd0, 32'hFFFF_FFFF);
    write_reg(3'd6, 32'd1);
    // adc: signed overflow, unsigned carry out, then carry in used
    exec_insn(reg_form(TOP10_ADC_REG, 3'd6, 3'd2));
    exec_insn(reg_form(TOP10_ADC_REG, 3'd6, 3'd0));
    exec_insn(reg_form(TOP10_ADC_REG, 3'd6, 3'd7));
    // shift count byte of 0xff
    write_reg(3'd5, 32'hFFFF_FFFF);
    exec_insn(reg_form(TOP10_LSL_REG, 3'd5, 3'd2));
    // illegal words leave everything alone
    exec_insn(16'hFFFF);
    exec_insn(reg_form(10'h104, 3'd1, 3'd2));

    // random mix: mostly legal instructions, some writes, some noise
    for (int n = 0; n < 900; n++) begin
      if ($urandom_range(0, 99) < 20) send_beat(1'b1, pick_insn(), 3'($urandom), pick_value());
      else send_beat(1'b0, pick_insn(), 3'($urandom), pick_value());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then keep watching the output to catch stray beats
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("beats: %0d writes, lsl imm %0d, lsr imm %0d, lsl reg %0d, lsr reg %0d, adc %0d, illegal %0d",
             sb.op_seen[OP_WRITE], sb.op_seen[OP_LSL_IMM], sb.op_seen[OP_LSR_IMM],
             sb.op_seen[OP_LSL_REG], sb.op_seen[OP_LSR_REG], sb.op_seen[OP_ADC],
             sb.op_seen[OP_ILLEGAL]);
    $display("results checked %0d, failures %0d, still awaited %0d",
             sb.checked, sb.failures, sb.pending());
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("thumb_shift_adc_execute_test OK");
    end else begin
      $display("thumb_shift_adc_execute_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
